/* rtl/core/handle_slot_table_core_assert.svh */
// Assertion macros used by the slot table core RTL
`ifndef HANDLE_SLOT_TABLE_CORE_ASSERT_SVH
`define HANDLE_SLOT_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define HST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hst_pkg.sv */
// Package: constants, codes and types of the handle slot table
`timescale 1ns / 1ps
`default_nettype none
package hst_pkg;

  localparam int SLOT_COUNT  = 64;
  localparam int HANDLE_BITS = 32;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int CMD_W       = 3;
  localparam int STAT_W      = 3;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] STAT_END       = 3'd3;
  localparam logic [STAT_W-1:0] STAT_BAD_ITEM  = 3'd4;

  localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(SLOT_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef struct packed {
    logic                   we;
    logic [IDX_W-1:0]       addr;
    logic [HANDLE_BITS-1:0] data;
  } hst_wr_t;

endpackage
`default_nettype wire

/* rtl/core/handle_slot_table_core.sv */
// Handle slot table: add, remove, clear and walk over a memory of handle slots
// Each command is accepted in IDLE, then SCAN examines slots from the start index up to
// the slot limit until one matches or all miss, and FIN issues the result once the output
// is free. Bad item and undefined commands skip SCAN and go straight to FIN. One item in
// flight; the memory read port examines one slot per cycle. Reset empties every slot at
// once through valid bits, zeroes count and cursor, and sets the slot limit to 64.
`timescale 1ns / 1ps
`default_nettype none
`include "handle_slot_table_core_assert.svh"
module handle_slot_table_core
  import hst_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CNT_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       in_cmd,
  input  wire logic [HANDLE_BITS-1:0] in_item_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [STAT_W-1:0]      out_status,
  output logic      [IDX_W-1:0]       out_slot_index,
  output logic      [HANDLE_BITS-1:0] out_item_out,
  output logic      [CNT_W-1:0]       out_live_count
);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       lim_cfg_r;
  logic [SLOT_COUNT-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0]       cur_r, cur_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic                   res_hit_r, res_hit_nxt;
  logic [STAT_W-1:0]      res_stat_r, res_stat_nxt;
  logic [IDX_W-1:0]       res_idx_r, res_idx_nxt;
  logic [HANDLE_BITS-1:0] res_item_r, res_item_nxt;
  logic [STAT_W-1:0]      out_stat_r, out_stat_nxt;
  logic [IDX_W-1:0]       out_idx_r, out_idx_nxt;
  logic [HANDLE_BITS-1:0] out_item_r, out_item_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;

  logic [CNT_W-1:0]       lim;
  logic                   chk_occ;
  logic                   chk_match;
  logic                   scan_end;
  logic                   out_free;
  hst_wr_t                wr;
  logic [HANDLE_BITS-1:0] rd_data;

  hst_slot_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign lim       = (lim_cfg_r > SLOTS_RESET) ? SLOTS_RESET : lim_cfg_r;
  assign chk_occ   = occ_r[chk_idx_r];
  assign scan_end  = !chk_vld_r && (scan_idx_r >= lim);
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    case (cmd_r)
      CMD_ADD:    chk_match = !chk_occ;
      CMD_REMOVE: chk_match = chk_occ && (rd_data == hdl_r);
      CMD_FIRST,
      CMD_NEXT:   chk_match = chk_occ;
      default:    chk_match = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    scan_idx_nxt  = scan_idx_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = chk_vld_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    hdl_nxt       = hdl_r;
    res_hit_nxt   = res_hit_r;
    res_stat_nxt  = res_stat_r;
    res_idx_nxt   = res_idx_r;
    res_item_nxt  = res_item_r;
    out_stat_nxt  = out_stat_r;
    out_idx_nxt   = out_idx_r;
    out_item_nxt  = out_item_r;
    out_cnt_nxt   = out_cnt_r;
    wr.we         = 1'b0;
    wr.addr       = res_idx_r;
    wr.data       = hdl_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_cmd;
          hdl_nxt      = in_item_value;
          chk_vld_nxt  = 1'b0;
          res_hit_nxt  = 1'b0;
          res_idx_nxt  = '0;
          res_item_nxt = '0;
          res_stat_nxt = STAT_OK;
          scan_idx_nxt = '0;
          case (in_cmd)
            CMD_ADD, CMD_REMOVE: begin
              if (in_item_value == '0) begin
                res_stat_nxt = STAT_BAD_ITEM;
                state_nxt    = ST_FIN;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_CLEAR, CMD_FIRST: state_nxt = ST_SCAN;
            CMD_NEXT: begin
              scan_idx_nxt = {1'b0, cur_r} + CNT_W'(1);
              state_nxt    = ST_SCAN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_r < lim) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
          chk_vld_nxt  = 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (cmd_r == CMD_CLEAR && chk_vld_r && chk_occ) begin
          occ_nxt[chk_idx_r] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        if (chk_vld_r && chk_match) begin
          res_hit_nxt  = 1'b1;
          res_idx_nxt  = chk_idx_r;
          res_stat_nxt = STAT_OK;
          res_item_nxt = (cmd_r == CMD_FIRST || cmd_r == CMD_NEXT) ? rd_data : '0;
          state_nxt    = ST_FIN;
        end else if (scan_end) begin
          res_hit_nxt = 1'b0;
          case (cmd_r)
            CMD_ADD:            res_stat_nxt = STAT_FULL;
            CMD_REMOVE:         res_stat_nxt = STAT_NOT_FOUND;
            CMD_FIRST, CMD_NEXT: res_stat_nxt = STAT_END;
            default:            res_stat_nxt = STAT_OK;
          endcase
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          if (res_hit_r) begin
            case (cmd_r)
              CMD_ADD: begin
                wr.we              = 1'b1;
                occ_nxt[res_idx_r] = 1'b1;
                cnt_nxt            = cnt_r + CNT_W'(1);
              end
              CMD_REMOVE: begin
                occ_nxt[res_idx_r] = 1'b0;
                if (cnt_r != '0) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
              end
              CMD_FIRST, CMD_NEXT: cur_nxt = res_idx_r;
              default: ;
            endcase
          end
          out_stat_nxt  = res_stat_r;
          out_idx_nxt   = res_idx_r;
          out_item_nxt  = res_item_r;
          out_cnt_nxt   = cnt_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lim_cfg_r   <= SLOTS_RESET;
      occ_r       <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        lim_cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    cmd_r      <= cmd_nxt;
    hdl_r      <= hdl_nxt;
    res_hit_r  <= res_hit_nxt;
    res_stat_r <= res_stat_nxt;
    res_idx_r  <= res_idx_nxt;
    res_item_r <= res_item_nxt;
    out_stat_r <= out_stat_nxt;
    out_idx_r  <= out_idx_nxt;
    out_item_r <= out_item_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_stat_r;
  assign out_slot_index = out_idx_r;
  assign out_item_out   = out_item_r;
  assign out_live_count = out_cnt_r;

  `HST_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= SLOTS_RESET, "live count above slot count")
  `HST_ASSERT_IMP(a_scan_max, 1'b1, scan_idx_r <= SLOTS_RESET, "scan index out of range")
  `HST_ASSERT_IMP(a_wr_fin, wr.we, state_r == ST_FIN && cmd_r == CMD_ADD, "write outside add result")
  `HST_ASSERT_NXT(a_acc_busy, in_valid && in_ready, state_r != ST_IDLE, "accept left block idle")
  `HST_ASSERT_IMP(a_err_zero, out_valid && out_status != STAT_OK,
    out_slot_index == '0 && out_item_out == '0, "error result carries slot data")

endmodule
`default_nettype wire

/* rtl/core/hst_slot_ram.sv */
// Slot handle memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module hst_slot_ram
  import hst_pkg::*;
(
  input  wire logic                   clk,
  input  wire hst_wr_t                wr,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic      [HANDLE_BITS-1:0] rd_data
);

  logic [HANDLE_BITS-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* bench/handle_slot_table_core_test.sv */
// Testbench for handle_slot_table_core: directed and random command traffic against a predictor
`timescale 1ns / 1ps
module handle_slot_table_core_test;
  import hst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [IDX_W-1:0]       slot;
    logic [HANDLE_BITS-1:0] item;
    logic [CNT_W-1:0]       count;
  } slot_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CNT_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [CMD_W-1:0]       in_cmd;
  logic [HANDLE_BITS-1:0] in_item_value;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STAT_W-1:0]      out_status;
  logic [IDX_W-1:0]       out_slot_index;
  logic [HANDLE_BITS-1:0] out_item_out;
  logic [CNT_W-1:0]       out_live_count;

  logic [HANDLE_BITS-1:0] shadow_slots [SLOT_COUNT];
  int                     shadow_count;
  int                     shadow_cursor;
  int                     shadow_limit;
  slot_result_t           pending_results [$];
  slot_result_t           want_result;

  int   failures       = 0;
  int   cycle_count    = 0;
  int   hold_cycles    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic offering       = 1'b0;

  handle_slot_table_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot_index (out_slot_index),
    .out_item_out   (out_item_out),
    .out_live_count (out_live_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk) begin
    out_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: status %0d slot %0d item %0h count %0d",
               out_status, out_slot_index, out_item_out, out_live_count);
        failures++;
      end else begin
        want_result = pending_results.pop_front();
        if (out_status !== want_result.status) begin
          $error("status expected %0d got %0d", want_result.status, out_status);
          failures++;
        end
        if (out_slot_index !== want_result.slot) begin
          $error("slot_index expected %0d got %0d", want_result.slot, out_slot_index);
          failures++;
        end
        if (out_item_out !== want_result.item) begin
          $error("item_out expected %0h got %0h", want_result.item, out_item_out);
          failures++;
        end
        if (out_live_count !== want_result.count) begin
          $error("live_count expected %0d got %0d", want_result.count, out_live_count);
          failures++;
        end
      end
    end
  end

  function automatic slot_result_t apply_to_shadow(input logic [CMD_W-1:0] cmd,
                                                   input logic [HANDLE_BITS-1:0] value);
    slot_result_t res;
    int span;
    int hit;
    int start;
    int i;
    span = (shadow_limit > SLOT_COUNT) ? SLOT_COUNT : shadow_limit;
    hit = -1;
    res = '0;
    res.status = STAT_OK;
    case (cmd)
      CMD_ADD, CMD_REMOVE: begin
        if (value == '0) begin
          res.status = STAT_BAD_ITEM;
        end else begin
          for (i = span - 1; i >= 0; i--) begin
            if ((cmd == CMD_ADD) ? (shadow_slots[i] == '0) : (shadow_slots[i] == value))
              hit = i;
          end
          if (hit < 0) begin
            res.status = (cmd == CMD_ADD) ? STAT_FULL : STAT_NOT_FOUND;
          end else if (cmd == CMD_ADD) begin
            shadow_slots[hit] = value;
            shadow_count++;
            res.slot = IDX_W'(hit);
          end else begin
            shadow_slots[hit] = '0;
            shadow_count--;
            res.slot = IDX_W'(hit);
          end
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < span; i++) begin
          if (shadow_slots[i] != '0) begin
            shadow_slots[i] = '0;
            shadow_count--;
          end
        end
      end
      CMD_FIRST, CMD_NEXT: begin
        start = (cmd == CMD_FIRST) ? 0 : shadow_cursor + 1;
        for (i = span - 1; i >= start; i--) begin
          if (shadow_slots[i] != '0) hit = i;
        end
        if (hit < 0) begin
          res.status = STAT_END;
        end else begin
          shadow_cursor = hit;
          res.slot = IDX_W'(hit);
          res.item = shadow_slots[hit];
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HANDLE_BITS-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_item_value <= value;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_to_shadow(cmd, value));
  endtask

  task automatic drain_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_slot_limit(input int limit);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= CNT_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_limit = limit;
  endtask

  task automatic send_random_item(input int add_pct);
    logic [HANDLE_BITS-1:0] held [$];
    logic [HANDLE_BITS-1:0] value;
    logic [CMD_W-1:0]       cmd;
    int r;
    int pick;
    int i;
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    value = $urandom;
    if (r < add_pct) begin
      cmd = CMD_ADD;
      if (pick < 3) value = '0;
      else if (pick < 33) value = HANDLE_BITS'($urandom_range(1, 6));
    end else if (r < add_pct + 20) begin
      cmd = CMD_REMOVE;
      for (i = 0; i < SLOT_COUNT; i++) begin
        if (shadow_slots[i] != '0) held.push_back(shadow_slots[i]);
      end
      if (pick < 10) value = '0;
      else if (pick < 85 && held.size() > 0) value = held[$urandom_range(0, held.size() - 1)];
    end else if (r < add_pct + 29) begin
      cmd = CMD_FIRST;
    end else if (r < add_pct + 31) begin
      cmd = CMD_CLEAR;
    end else if (r < add_pct + 33) begin
      cmd = CMD_W'($urandom_range(CMD_NEXT + 1, CMD_LAST_CODE));
    end else begin
      cmd = CMD_NEXT;
    end
    send_item(cmd, value);
  endtask

  // next before any first continues from the reset cursor
  task automatic test_walk_from_reset();
    send_item(CMD_NEXT, '0);
    send_item(CMD_ADD, '1);
    send_item(CMD_ADD, HANDLE_BITS'(1));
    send_item(CMD_NEXT, '0);
  endtask

  task automatic test_handles_and_walk();
    send_item(CMD_ADD, '0);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_ADD, HANDLE_BITS'(1));
    send_item(CMD_REMOVE, HANDLE_BITS'(1));
    send_item(CMD_REMOVE, 32'h1234_5678);
    send_item(CMD_FIRST, '0);
    send_item(CMD_NEXT, '0);
    send_item(CMD_NEXT, '0);
  endtask

  task automatic test_undefined_commands();
    int c;
    for (c = CMD_NEXT + 1; c <= CMD_LAST_CODE; c++) send_item(CMD_W'(c), $urandom);
  endtask

  task automatic test_slot_limits();
    set_slot_limit(0);
    send_item(CMD_ADD, 32'h5);
    send_item(CMD_REMOVE, '1);
    send_item(CMD_FIRST, '0);
    send_item(CMD_CLEAR, '0);
    set_slot_limit(127);
    send_item(CMD_ADD, 32'h5);
    // clear reaches only the first two slots
    set_slot_limit(2);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_ADD, 32'hA);
    send_item(CMD_ADD, 32'hB);
    send_item(CMD_ADD, 32'hC);
    set_slot_limit(SLOT_COUNT);
    send_item(CMD_FIRST, '0);
  endtask

  task automatic test_backpressure();
    drain_results();
    hold_cycles <= 300;
    repeat (6) send_item(CMD_ADD, $urandom | 32'h1);
    send_item(CMD_FIRST, '0);
    send_item(CMD_NEXT, '0);
  endtask

  task automatic test_random_traffic();
    int phase;
    int chunk;
    int limit;
    int add_pct;
    for (phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        case ($urandom_range(0, 7))
          0: limit = 1;
          1: limit = $urandom_range(2, 8);
          2: limit = $urandom_range(9, 63);
          6: limit = $urandom_range(65, 127);
          7: limit = 0;
          default: limit = SLOT_COUNT;
        endcase
        set_slot_limit(limit);
        add_pct = $urandom_range(30, 70);
        repeat (47) send_random_item(add_pct);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_cmd <= CMD_ADD;
    in_item_value <= '0;
    for (int i = 0; i < SLOT_COUNT; i++) shadow_slots[i] = '0;
    shadow_count = 0;
    shadow_cursor = 0;
    shadow_limit = SLOTS_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_walk_from_reset();
    test_handles_and_walk();
    test_undefined_commands();
    test_slot_limits();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (80) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hst_pkg.sv
rtl/core/hst_slot_ram.sv
rtl/core/handle_slot_table_core.sv
bench/handle_slot_table_core_test.sv
